// File: sv/assert_macros.svh
// Assertion macros shared by the name decompressor modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A consequent that must hold in the same cycle as its antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A consequent that must hold in the cycle after its antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/dnd_pkg.sv
// Shared constants, types and the microcode table of the DNS name decompressor.
package dnd_pkg;

    // Storage sizes.
    localparam int MSG_BYTES  = 512;
    localparam int NAME_LIMIT = 255;

    // Port field widths.
    localparam int OP_W   = 2;
    localparam int ADDR_W = 9;
    localparam int BYTE_W = 8;
    localparam int MLEN_W = 10;
    localparam int ST_W   = 3;
    localparam int LBL_W  = 7;
    localparam int NLEN_W = 8;
    localparam int USED_W = 10;

    // Derived internal widths.
    localparam int LABEL_MAX = 63;
    localparam int MSG_AW    = $clog2(MSG_BYTES);
    localparam int POS_W     = $clog2(MSG_BYTES + 1);
    localparam int NAME_AW   = $clog2(NAME_LIMIT);
    localparam int LEN_W     = $clog2(NAME_LIMIT + 1);
    localparam int TOT_W     = $clog2(NAME_LIMIT + 1);
    localparam int SUM_W     = $clog2(NAME_LIMIT + LABEL_MAX + 2);
    localparam int OFS_W     = 6;
    localparam int TGT_W     = OFS_W + BYTE_W;
    localparam int STEP_W    = 5;

    // Wire-format codes.
    localparam logic [BYTE_W-1:0] LEN_CODE_TOP  = 8'd64;
    localparam logic [BYTE_W-1:0] PTR_CODE_BASE = 8'd192;
    localparam logic [BYTE_W-1:0] OFS_MASK      = 8'h3F;
    localparam logic [BYTE_W-1:0] DOT_CHAR      = 8'h2E;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 3'd0,
        ST_BAD_LABEL = 3'd1,
        ST_FORWARD   = 3'd2,
        ST_TOO_LONG  = 3'd3,
        ST_RAN_OUT   = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        A_NOP,
        A_WRITE_MSG,
        A_INIT,
        A_READ_NAME,
        A_FETCH,
        A_LABEL,
        A_DOT,
        A_CHAR,
        A_TARGET_HI,
        A_TARGET_LO,
        A_COMMIT,
        A_FAIL,
        A_DELIVER
    } action_t;

    typedef enum logic [3:0] {
        C_NONE,
        C_ALWAYS,
        C_DISPATCH,
        C_RAN_OUT,
        C_BAD_LABEL,
        C_POINTER,
        C_TOO_LONG,
        C_END_MARK,
        C_MORE_CHARS,
        C_FORWARD,
        C_OUT_FREE
    } cond_t;

    typedef logic [STEP_W-1:0] step_t;

    // Program steps. The four dispatch entries follow the operation codes.
    localparam step_t S_IDLE       = step_t'(0);
    localparam step_t S_LOAD       = step_t'(1);
    localparam step_t S_DECODE     = step_t'(2);
    localparam step_t S_READ       = step_t'(3);
    localparam step_t S_SPARE      = step_t'(4);
    localparam step_t S_LEN_FETCH  = step_t'(5);
    localparam step_t S_LEN_CHECK  = step_t'(6);
    localparam step_t S_LEN_PTR    = step_t'(7);
    localparam step_t S_LEN_COUNT  = step_t'(8);
    localparam step_t S_LEN_END    = step_t'(9);
    localparam step_t S_DOT        = step_t'(10);
    localparam step_t S_CHAR_FETCH = step_t'(11);
    localparam step_t S_CHAR_STORE = step_t'(12);
    localparam step_t S_CHAR_LAST  = step_t'(13);
    localparam step_t S_PTR_HI     = step_t'(14);
    localparam step_t S_PTR_FETCH  = step_t'(15);
    localparam step_t S_PTR_LO     = step_t'(16);
    localparam step_t S_PTR_JUMP   = step_t'(17);
    localparam step_t S_OK         = step_t'(18);
    localparam step_t S_BAD_LABEL  = step_t'(19);
    localparam step_t S_FORWARD    = step_t'(20);
    localparam step_t S_TOO_LONG   = step_t'(21);
    localparam step_t S_RAN_OUT    = step_t'(22);
    localparam step_t S_DONE       = step_t'(23);
    localparam step_t S_LAST       = S_DONE;

    typedef struct packed {
        action_t action;
        cond_t   cond;
        step_t   target;
        status_t status;
        logic    hold;
    } cword_t;

    // Datapath conditions seen by the sequencer.
    typedef struct packed {
        logic ran_out;
        logic bad_label;
        logic pointer;
        logic too_long;
        logic end_mark;
        logic more_chars;
        logic forward;
        logic out_free;
    } flags_t;

    // Sequencer commands to the datapath.
    typedef struct packed {
        action_t action;
        status_t status;
        logic    accept;
    } ctrl_t;

    function automatic cword_t cw(action_t a, cond_t c, step_t t, status_t s, logic h);
        cword_t w;
        w.action = a;
        w.cond   = c;
        w.target = t;
        w.status = s;
        w.hold   = h;
        return w;
    endfunction

    // Microcode table. A true condition jumps to the target, plus the operation code on a
    // dispatch; otherwise the step either holds or falls through to the next one.
    function automatic cword_t ucode(step_t s);
        cword_t w;
        unique case (s)
            S_IDLE:       w = cw(A_NOP,       C_DISPATCH,   S_LOAD,       ST_OK,        1'b1);
            S_LOAD:       w = cw(A_WRITE_MSG, C_ALWAYS,     S_DONE,       ST_OK,        1'b0);
            S_DECODE:     w = cw(A_INIT,      C_ALWAYS,     S_LEN_FETCH,  ST_OK,        1'b0);
            S_READ:       w = cw(A_READ_NAME, C_ALWAYS,     S_DONE,       ST_OK,        1'b0);
            S_SPARE:      w = cw(A_NOP,       C_ALWAYS,     S_DONE,       ST_OK,        1'b0);
            S_LEN_FETCH:  w = cw(A_FETCH,     C_RAN_OUT,    S_RAN_OUT,    ST_OK,        1'b0);
            S_LEN_CHECK:  w = cw(A_NOP,       C_BAD_LABEL,  S_BAD_LABEL,  ST_OK,        1'b0);
            S_LEN_PTR:    w = cw(A_NOP,       C_POINTER,    S_PTR_HI,     ST_OK,        1'b0);
            S_LEN_COUNT:  w = cw(A_LABEL,     C_TOO_LONG,   S_TOO_LONG,   ST_OK,        1'b0);
            S_LEN_END:    w = cw(A_NOP,       C_END_MARK,   S_OK,         ST_OK,        1'b0);
            S_DOT:        w = cw(A_DOT,       C_NONE,       S_IDLE,       ST_OK,        1'b0);
            S_CHAR_FETCH: w = cw(A_FETCH,     C_RAN_OUT,    S_RAN_OUT,    ST_OK,        1'b0);
            S_CHAR_STORE: w = cw(A_CHAR,      C_MORE_CHARS, S_CHAR_FETCH, ST_OK,        1'b0);
            S_CHAR_LAST:  w = cw(A_NOP,       C_ALWAYS,     S_LEN_FETCH,  ST_OK,        1'b0);
            S_PTR_HI:     w = cw(A_TARGET_HI, C_NONE,       S_IDLE,       ST_OK,        1'b0);
            S_PTR_FETCH:  w = cw(A_FETCH,     C_RAN_OUT,    S_RAN_OUT,    ST_OK,        1'b0);
            S_PTR_LO:     w = cw(A_TARGET_LO, C_FORWARD,    S_FORWARD,    ST_OK,        1'b0);
            S_PTR_JUMP:   w = cw(A_NOP,       C_ALWAYS,     S_LEN_FETCH,  ST_OK,        1'b0);
            S_OK:         w = cw(A_COMMIT,    C_ALWAYS,     S_DONE,       ST_OK,        1'b0);
            S_BAD_LABEL:  w = cw(A_FAIL,      C_ALWAYS,     S_DONE,       ST_BAD_LABEL, 1'b0);
            S_FORWARD:    w = cw(A_FAIL,      C_ALWAYS,     S_DONE,       ST_FORWARD,   1'b0);
            S_TOO_LONG:   w = cw(A_FAIL,      C_ALWAYS,     S_DONE,       ST_TOO_LONG,  1'b0);
            S_RAN_OUT:    w = cw(A_FAIL,      C_ALWAYS,     S_DONE,       ST_RAN_OUT,   1'b0);
            S_DONE:       w = cw(A_DELIVER,   C_OUT_FREE,   S_IDLE,       ST_OK,        1'b1);
            default:      w = cw(A_NOP,       C_ALWAYS,     S_IDLE,       ST_OK,        1'b0);
        endcase
        return w;
    endfunction

endpackage

// File: sv/dnd_sequencer.sv
// Step counter, microcode fetch and jump logic of the name decompressor.
`include "assert_macros.svh"

module dnd_sequencer (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    input  logic [dnd_pkg::OP_W-1:0]  operation,
    input  dnd_pkg::flags_t           flags,
    output logic                      item_stall,
    output dnd_pkg::ctrl_t            ctrl
);
    import dnd_pkg::*;

    step_t  upc_reg;
    step_t  upc_next;
    cword_t word;
    logic   idle;
    logic   cond_true;

    assign word = ucode(upc_reg);
    assign idle = (upc_reg == S_IDLE);

    always_comb
    begin
        unique case (word.cond)
            C_NONE:       cond_true = 1'b0;
            C_ALWAYS:     cond_true = 1'b1;
            C_DISPATCH:   cond_true = item_valid;
            C_RAN_OUT:    cond_true = flags.ran_out;
            C_BAD_LABEL:  cond_true = flags.bad_label;
            C_POINTER:    cond_true = flags.pointer;
            C_TOO_LONG:   cond_true = flags.too_long;
            C_END_MARK:   cond_true = flags.end_mark;
            C_MORE_CHARS: cond_true = flags.more_chars;
            C_FORWARD:    cond_true = flags.forward;
            C_OUT_FREE:   cond_true = flags.out_free;
            default:      cond_true = 1'b0;
        endcase
    end

    always_comb
    begin
        priority if (word.cond == C_DISPATCH && cond_true)
        begin
            // Multi-way branch on the operation code of the accepted beat.
            upc_next = step_t'(word.target + step_t'(operation));
        end
        else if (cond_true)
        begin
            upc_next = word.target;
        end
        else if (word.hold)
        begin
            upc_next = upc_reg;
        end
        else
        begin
            upc_next = step_t'(upc_reg + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= S_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    assign item_stall  = !idle;
    assign ctrl.action = word.action;
    assign ctrl.status = word.status;
    assign ctrl.accept = idle && item_valid;

    `ASSERT_ALWAYS(a_upc_in_program, upc_reg <= S_LAST, "Step counter left the program.")
    `ASSERT_NEXT(a_dispatch_entry, ctrl.accept, (upc_reg == S_LOAD || upc_reg == S_DECODE || upc_reg == S_READ || upc_reg == S_SPARE), "Accepted beat did not dispatch.")

endmodule

// File: sv/dnd_datapath.sv
// Message store, double-banked name buffer, walk registers and result register.
`include "assert_macros.svh"

module dnd_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  dnd_pkg::ctrl_t              ctrl,
    input  logic [dnd_pkg::ADDR_W-1:0]  address,
    input  logic [dnd_pkg::BYTE_W-1:0]  byte_value,
    input  logic [dnd_pkg::MLEN_W-1:0]  msg_length,
    input  logic                        result_stall,
    output dnd_pkg::flags_t             flags,
    output logic                        result_valid,
    output logic [dnd_pkg::ST_W-1:0]    status,
    output logic [dnd_pkg::LBL_W-1:0]   label_count,
    output logic [dnd_pkg::NLEN_W-1:0]  name_length,
    output logic [dnd_pkg::USED_W-1:0]  bytes_used,
    output logic [dnd_pkg::BYTE_W-1:0]  name_byte
);
    import dnd_pkg::*;

    logic [BYTE_W-1:0] msg_mem  [0:MSG_BYTES-1];
    logic [BYTE_W-1:0] name_mem [0:(2**(NAME_AW+1))-1];

    // Latched beat fields.
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic [POS_W-1:0]  end_reg, end_next;

    // Walk state.
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [POS_W-1:0]  lowest_reg, lowest_next;
    logic [POS_W-1:0]  used_reg, used_next;
    logic [TOT_W-1:0]  total_reg, total_next;
    logic [LBL_W-1:0]  labels_reg, labels_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [OFS_W-1:0]  rem_reg, rem_next;
    logic [OFS_W-1:0]  tgt_hi_reg, tgt_hi_next;
    logic              jumped_reg, jumped_next;
    logic [BYTE_W-1:0] msg_rd_reg;
    logic [BYTE_W-1:0] name_rd_reg;
    logic              nbyte_ok_reg, nbyte_ok_next;

    // Summary of the last decode and the committed name.
    status_t           last_status_reg, last_status_next;
    logic [LBL_W-1:0]  last_labels_reg, last_labels_next;
    logic [LEN_W-1:0]  last_length_reg, last_length_next;
    logic [POS_W-1:0]  last_used_reg, last_used_next;
    logic              commit_bank_reg, commit_bank_next;
    logic [LEN_W-1:0]  commit_len_reg, commit_len_next;

    // Result register.
    logic              res_valid_reg, res_valid_next;
    logic [ST_W-1:0]   st_out_reg, st_out_next;
    logic [LBL_W-1:0]  lbl_out_reg, lbl_out_next;
    logic [NLEN_W-1:0] len_out_reg, len_out_next;
    logic [USED_W-1:0] used_out_reg, used_out_next;
    logic [BYTE_W-1:0] nbyte_out_reg, nbyte_out_next;

    // Memory port controls.
    logic              msg_we;
    logic              msg_re;
    logic              name_we;
    logic              name_re;
    logic [BYTE_W-1:0] name_wdata;

    logic [BYTE_W-1:0] c;
    logic [SUM_W-1:0]  label_sum;
    logic [TGT_W-1:0]  tgt;
    logic              len_room;

    assign c         = msg_rd_reg;
    assign label_sum = SUM_W'(total_reg) + SUM_W'(c & OFS_MASK) + SUM_W'(1);
    assign tgt       = {tgt_hi_reg, c};
    assign len_room  = 32'(len_reg) < NAME_LIMIT;

    assign flags.ran_out    = pos_reg >= end_reg;
    assign flags.bad_label  = (c >= LEN_CODE_TOP) && (c < PTR_CODE_BASE);
    assign flags.pointer    = c >= PTR_CODE_BASE;
    assign flags.too_long   = 32'(label_sum) > NAME_LIMIT;
    assign flags.end_mark   = c == '0;
    assign flags.more_chars = rem_reg != OFS_W'(1);
    assign flags.forward    = 32'(tgt) >= 32'(lowest_reg);
    assign flags.out_free   = !res_valid_reg || !result_stall;

    always_comb
    begin
        addr_next        = addr_reg;
        byte_next        = byte_reg;
        end_next         = end_reg;
        pos_next         = pos_reg;
        lowest_next      = lowest_reg;
        used_next        = used_reg;
        total_next       = total_reg;
        labels_next      = labels_reg;
        len_next         = len_reg;
        rem_next         = rem_reg;
        tgt_hi_next      = tgt_hi_reg;
        jumped_next      = jumped_reg;
        nbyte_ok_next    = nbyte_ok_reg;
        last_status_next = last_status_reg;
        last_labels_next = last_labels_reg;
        last_length_next = last_length_reg;
        last_used_next   = last_used_reg;
        commit_bank_next = commit_bank_reg;
        commit_len_next  = commit_len_reg;
        res_valid_next   = res_valid_reg && result_stall;
        st_out_next      = st_out_reg;
        lbl_out_next     = lbl_out_reg;
        len_out_next     = len_out_reg;
        used_out_next    = used_out_reg;
        nbyte_out_next   = nbyte_out_reg;
        msg_we           = 1'b0;
        msg_re           = 1'b0;
        name_we          = 1'b0;
        name_re          = 1'b0;
        name_wdata       = c;

        unique case (ctrl.action)
            A_NOP:
            begin
            end
            A_WRITE_MSG:
            begin
                msg_we = 32'(addr_reg) < MSG_BYTES;
            end
            A_INIT:
            begin
                pos_next    = POS_W'(addr_reg);
                lowest_next = POS_W'(addr_reg);
                used_next   = '0;
                total_next  = '0;
                labels_next = '0;
                len_next    = '0;
                jumped_next = 1'b0;
            end
            A_READ_NAME:
            begin
                name_re       = 1'b1;
                nbyte_ok_next = 32'(addr_reg) < 32'(commit_len_reg);
            end
            A_FETCH:
            begin
                if (!flags.ran_out)
                begin
                    msg_re    = 1'b1;
                    pos_next  = POS_W'(pos_reg + 1'b1);
                    used_next = POS_W'(used_reg + POS_W'(!jumped_reg));
                end
            end
            A_LABEL:
            begin
                labels_next = LBL_W'(labels_reg + LBL_W'(c != '0));
                rem_next    = OFS_W'(c & OFS_MASK);
                if (!flags.too_long)
                begin
                    total_next = TOT_W'(label_sum);
                end
            end
            A_DOT:
            begin
                // Labels after the first are preceded by a dot.
                if (labels_reg != LBL_W'(1) && len_room)
                begin
                    name_we    = 1'b1;
                    name_wdata = DOT_CHAR;
                    len_next   = LEN_W'(len_reg + 1'b1);
                end
            end
            A_CHAR:
            begin
                rem_next = OFS_W'(rem_reg - 1'b1);
                if (len_room)
                begin
                    name_we  = 1'b1;
                    len_next = LEN_W'(len_reg + 1'b1);
                end
            end
            A_TARGET_HI:
            begin
                tgt_hi_next = OFS_W'(c & OFS_MASK);
            end
            A_TARGET_LO:
            begin
                pos_next    = POS_W'(tgt);
                lowest_next = POS_W'(tgt);
                jumped_next = 1'b1;
            end
            A_COMMIT:
            begin
                last_status_next = ST_OK;
                last_labels_next = labels_reg;
                last_length_next = len_reg;
                last_used_next   = used_reg;
                commit_bank_next = !commit_bank_reg;
                commit_len_next  = len_reg;
            end
            A_FAIL:
            begin
                last_status_next = ctrl.status;
                last_labels_next = '0;
                last_length_next = '0;
                last_used_next   = '0;
            end
            A_DELIVER:
            begin
                if (flags.out_free)
                begin
                    res_valid_next = 1'b1;
                    st_out_next    = last_status_reg;
                    lbl_out_next   = last_labels_reg;
                    len_out_next   = NLEN_W'(last_length_reg);
                    used_out_next  = USED_W'(last_used_reg);
                    nbyte_out_next = nbyte_ok_reg ? name_rd_reg : '0;
                end
            end
            default:
            begin
            end
        endcase

        if (ctrl.accept)
        begin
            addr_next     = address;
            byte_next     = byte_value;
            nbyte_ok_next = 1'b0;
            end_next      = (32'(msg_length) > MSG_BYTES) ? POS_W'(MSG_BYTES)
                                                          : POS_W'(msg_length);
        end
    end

    always_ff @(posedge clk)
    begin
        if (msg_we)
        begin
            msg_mem[MSG_AW'(addr_reg)] <= byte_reg;
        end
        if (msg_re)
        begin
            msg_rd_reg <= msg_mem[MSG_AW'(pos_reg)];
        end
    end

    // The walk writes the idle bank; a successful decode swaps the banks.
    always_ff @(posedge clk)
    begin
        if (name_we)
        begin
            name_mem[{!commit_bank_reg, len_reg[NAME_AW-1:0]}] <= name_wdata;
        end
        if (name_re)
        begin
            name_rd_reg <= name_mem[{commit_bank_reg, addr_reg[NAME_AW-1:0]}];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg       <= '0;
            labels_reg      <= '0;
            len_reg         <= '0;
            nbyte_ok_reg    <= 1'b0;
            last_status_reg <= ST_OK;
            last_labels_reg <= '0;
            last_length_reg <= '0;
            last_used_reg   <= '0;
            commit_bank_reg <= 1'b0;
            commit_len_reg  <= '0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            total_reg       <= total_next;
            labels_reg      <= labels_next;
            len_reg         <= len_next;
            nbyte_ok_reg    <= nbyte_ok_next;
            last_status_reg <= last_status_next;
            last_labels_reg <= last_labels_next;
            last_length_reg <= last_length_next;
            last_used_reg   <= last_used_next;
            commit_bank_reg <= commit_bank_next;
            commit_len_reg  <= commit_len_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg      <= addr_next;
        byte_reg      <= byte_next;
        end_reg       <= end_next;
        pos_reg       <= pos_next;
        lowest_reg    <= lowest_next;
        used_reg      <= used_next;
        rem_reg       <= rem_next;
        tgt_hi_reg    <= tgt_hi_next;
        jumped_reg    <= jumped_next;
        st_out_reg    <= st_out_next;
        lbl_out_reg   <= lbl_out_next;
        len_out_reg   <= len_out_next;
        used_out_reg  <= used_out_next;
        nbyte_out_reg <= nbyte_out_next;
    end

    assign result_valid = res_valid_reg;
    assign status       = st_out_reg;
    assign label_count  = lbl_out_reg;
    assign name_length  = len_out_reg;
    assign bytes_used   = used_out_reg;
    assign name_byte    = nbyte_out_reg;

    `ASSERT_ALWAYS(a_total_in_limit, 32'(total_reg) <= NAME_LIMIT, "Name total passed the limit.")
    `ASSERT_ALWAYS(a_len_within_total, 32'(len_reg) <= 32'(total_reg), "Name length exceeds counted bytes.")
    `ASSERT_IMPLIES(a_commit_labels, ctrl.action == A_COMMIT, 32'(labels_reg) <= 32'(len_reg), "More labels than name characters at commit.")

endmodule

// File: sv/dns_name_decompressor.sv
// Top level of the DNS name decompressor: microcoded sequencer plus datapath.
// Loads, name reads and unused codes go through accept, one routine step and result.
// A decode runs length, dot, character and pointer steps; the sequencer runs one step
// per clock unless the result step waits, and each message byte costs one store read.
// Reset (rst_n low, asynchronous) idles the sequencer, drops the result beat, zeroes
// the decode summary and makes the name read back as zeros; the message store is kept.
module dns_name_decompressor (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_stall,
    input  logic [dnd_pkg::OP_W-1:0]    operation,
    input  logic [dnd_pkg::ADDR_W-1:0]  address,
    input  logic [dnd_pkg::BYTE_W-1:0]  byte_value,
    input  logic [dnd_pkg::MLEN_W-1:0]  msg_length,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic [dnd_pkg::ST_W-1:0]    status,
    output logic [dnd_pkg::LBL_W-1:0]   label_count,
    output logic [dnd_pkg::NLEN_W-1:0]  name_length,
    output logic [dnd_pkg::USED_W-1:0]  bytes_used,
    output logic [dnd_pkg::BYTE_W-1:0]  name_byte
);
    import dnd_pkg::*;

    // The sequencer owns the program counter and the input handshake. A beat
    // is taken only at the idle step, which dispatches on the operation code
    // into one of four short routines.
    //
    // The decode routine walks the message one byte per fetch step. Length
    // bytes are classified over a few steps (bad label type, pointer, name
    // limit, end of name), label characters are copied into the name buffer,
    // and a pointer replaces the walk position after checking that it points
    // strictly below every offset reached so far.
    //
    // The name buffer has two banks. A decode fills the bank that is not
    // visible; only a successful decode swaps banks and records the new name
    // length, so a failed decode leaves the visible name untouched. Reads past
    // the committed length return zero, which stands in for the zero fill.
    //
    // Results go through a one-entry output register, so the next beat can be
    // accepted and worked on while the previous result beat is still stalled.
    // The final step of each routine waits only when that register is full and stalled.
    flags_t flags;
    ctrl_t  ctrl;

    dnd_sequencer u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .operation  (operation),
        .flags      (flags),
        .item_stall (item_stall),
        .ctrl       (ctrl)
    );

    dnd_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .address      (address),
        .byte_value   (byte_value),
        .msg_length   (msg_length),
        .result_stall (result_stall),
        .flags        (flags),
        .result_valid (result_valid),
        .status       (status),
        .label_count  (label_count),
        .name_length  (name_length),
        .bytes_used   (bytes_used),
        .name_byte    (name_byte)
    );

endmodule
